// ===== rtl/dtti64_pkg.sv =====
// dtti64_pkg: types and constants for the decimal text to int64 parser
// character codes, parse phase encoding and signed 64-bit limits
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dtti64_pkg;

   typedef enum logic [1:0] {
      PH_SPACE  = 2'd0,
      PH_DIGITS = 2'd1,
      PH_DONE   = 2'd2
   } phase_type;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam logic signed [63:0] VALUE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] VALUE_MIN = 64'sh8000_0000_0000_0000;

   // largest magnitude that may still take another digit, and the last digit allowed there
   localparam logic signed [63:0] CUT_POS = 64'sh0CCC_CCCC_CCCC_CCCC;
   localparam logic signed [63:0] CUT_NEG = 64'shF333_3333_3333_3334;
   localparam logic [3:0]         LIM_POS = 4'd7;
   localparam logic [3:0]         LIM_NEG = 4'd8;

endpackage

`default_nettype wire

// ===== rtl/decimal_text_to_int64.sv =====
// decimal_text_to_int64: streaming signed decimal text to 64-bit integer, saturating
// one character per request, one result per end-marked string
// depends on dtti64_pkg
// result path: input register stage, then result register, after the tlast request is accepted
// throughput: one character per cycle unless a final character waits on the result side;
//   the combinational parse step (accumulator * 10 +/- the digit, with the limit compare) sets it
// reset: synchronous, active high; clears the input and result valids and the parse
//   state (white space phase, positive, accumulator and overflow flag zero)
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_int64
   import dtti64_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // character request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tlast,   // end_of_string
   // parsed value channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,   // [63:0] value (signed)
   output      logic [0:0]  rsp_tuser    // [0] overflowed
);

   // input register stage
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_char_ff;
   logic        s1_last_ff;

   // parse state
   phase_type          phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic signed [63:0] acc_ff, acc_in;
   logic               ovf_ff, ovf_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [63:0] rsp_value_ff;
   logic               rsp_ovf_ff;

   // control
   logic out_free;
   logic proc;
   logic req_fire;

   // character classification
   logic       is_digit;
   logic       is_blank;
   logic [3:0] digit;
   logic       take_digit;

   // datapath
   logic signed [63:0] acc_x10;
   logic signed [63:0] dig_ext;
   logic signed [63:0] acc_step;
   logic               over;
   logic               neg_upd;
   logic signed [63:0] acc_upd;
   logic               ovf_upd;

   // the result register frees up this cycle if empty or being taken
   assign out_free = !rsp_valid_ff || rsp_tready;
   // a non-final character never waits on the result side
   assign proc       = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || proc;
   assign req_fire   = req_tvalid && req_tready;

   assign is_digit = (s1_char_ff >= CHAR_ZERO) && (s1_char_ff <= CHAR_NINE);
   assign is_blank = (s1_char_ff == CHAR_SPACE) ||
                     ((s1_char_ff >= CHAR_TAB) && (s1_char_ff <= CHAR_CR));
   assign digit    = s1_char_ff[3:0];

   // a digit counts only while white space or digits are being taken
   assign take_digit = is_digit && ((phase_ff == PH_SPACE) || (phase_ff == PH_DIGITS));

   // accumulator kept signed, so the negative side grows downward and never needs a negate
   assign acc_x10  = {acc_ff[60:0], 3'b000} + {acc_ff[62:0], 1'b0};
   assign dig_ext  = {60'd0, digit};
   assign acc_step = neg_ff ? (acc_x10 - dig_ext) : (acc_x10 + dig_ext);

   // limit check made on the accumulator before the digit goes in
   assign over = neg_ff ? ((acc_ff < CUT_NEG) || ((acc_ff == CUT_NEG) && (digit > LIM_NEG)))
                        : ((acc_ff > CUT_POS) || ((acc_ff == CUT_POS) && (digit > LIM_POS)));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (proc) begin
         if (s1_last_ff) begin
            phase_in = PH_SPACE;
         end else begin
            case (phase_ff)
               PH_SPACE: begin
                  if (is_blank) begin
                     phase_in = PH_SPACE;
                  end else if ((s1_char_ff == CHAR_MINUS) || (s1_char_ff == CHAR_PLUS)) begin
                     phase_in = PH_DIGITS;
                  end else if (is_digit) begin
                     phase_in = over ? PH_DONE : PH_DIGITS;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_DIGITS: begin
                  if (is_digit && !over) begin
                     phase_in = PH_DIGITS;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end
   end

   // sign, accumulator and overflow after this character
   always_comb begin
      neg_upd = neg_ff;
      acc_upd = acc_ff;
      ovf_upd = ovf_ff;
      if ((phase_ff == PH_SPACE) && (s1_char_ff == CHAR_MINUS)) begin
         neg_upd = 1'b1;
      end
      if (take_digit) begin
         if (over) begin
            // saturate; later digits are not looked at because the phase goes done
            acc_upd = neg_ff ? VALUE_MIN : VALUE_MAX;
            ovf_upd = 1'b1;
         end else begin
            acc_upd = acc_step;
         end
      end
   end

   // state register next values; end of string returns to the reset state
   always_comb begin
      neg_in = neg_ff;
      acc_in = acc_ff;
      ovf_in = ovf_ff;
      if (proc) begin
         if (s1_last_ff) begin
            neg_in = 1'b0;
            acc_in = '0;
            ovf_in = 1'b0;
         end else begin
            neg_in = neg_upd;
            acc_in = acc_upd;
            ovf_in = ovf_upd;
         end
      end
   end

   // input stage valid
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (proc) begin
         s1_valid_in = 1'b0;
      end
   end

   // result valid: set by a processed final character, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (proc && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_SPACE;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_char_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (proc && s1_last_ff) begin
         rsp_value_ff <= acc_upd;
         rsp_ovf_ff   <= ovf_upd;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_value_ff;
   assign rsp_tuser[0] = rsp_ovf_ff;

   // a new result only follows a processed end-of-string character
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("result appeared without an end-of-string character");

   // an overflowed result carries one of the two limits
   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |->
         ((rsp_value_ff == VALUE_MAX) || (rsp_value_ff == VALUE_MIN)))
      else $error("overflowed result is not saturated");

   // the parse state is clean after an end-of-string character
   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      (proc && s1_last_ff) |=> ((phase_ff == PH_SPACE) && (acc_ff == 0) && !ovf_ff && !neg_ff))
      else $error("parse state not cleared after end of string");

   // while still skipping white space nothing has been accumulated
   a_space_empty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SPACE) |-> ((acc_ff == 0) && !ovf_ff))
      else $error("accumulator busy during white space phase");

endmodule

`default_nettype wire

// ===== sim/decimal_text_to_int64_tb.sv =====
// decimal_text_to_int64_tb: self-checking bench for the streaming decimal text parser
// drives strings of characters, predicts each parsed value and compares it on the rsp side
// depends on dtti64_pkg and decimal_text_to_int64
`timescale 1ns / 1ps

module decimal_text_to_int64_tb;
   import dtti64_pkg::*;

   localparam logic [63:0] POS_MAG     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_MAG     = 64'h8000_0000_0000_0000;
   localparam int          STALL_LIMIT = 2000;
   localparam int          PHASE_CHARS = 217;

   typedef struct packed {
      logic [63:0] value;
      logic        overflowed;
   } parsed_type;

   // tracks the parse of the string in flight and holds the values still owed by the block
   class parsed_value_board_type;
      phase_type ph;
      bit        neg;
      logic [63:0] mag;
      bit        ovf;
      parsed_type owed_q[$];
      int        failures;
      int        results_seen;
      int        overflows_seen;

      function new();
         clear_parse();
         failures       = 0;
         results_seen   = 0;
         overflows_seen = 0;
      endfunction

      function void clear_parse();
         ph  = PH_SPACE;
         neg = 1'b0;
         mag = '0;
         ovf = 1'b0;
      endfunction

      // the limit test comes before the multiply, so saturation freezes the magnitude
      function void take_digit(logic [3:0] d);
         logic [63:0] limit;
         logic [63:0] cut;
         logic [63:0] lim;
         limit = neg ? NEG_MAG : POS_MAG;
         cut   = limit / 64'd10;
         lim   = limit % 64'd10;
         if (mag > cut || (mag == cut && {60'd0, d} > lim)) begin
            ovf = 1'b1;
            ph  = PH_DONE;
         end else begin
            mag = mag * 64'd10 + {60'd0, d};
            ph  = PH_DIGITS;
         end
      endfunction

      function void note_char(logic [7:0] c, logic last);
         parsed_type r;
         bit      is_digit;
         bit      is_blank;
         is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
         is_blank = (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR));
         case (ph)
            PH_SPACE: begin
               if (is_blank) begin
                  ph = PH_SPACE;
               end else if (c == CHAR_MINUS) begin
                  neg = 1'b1;
                  ph  = PH_DIGITS;
               end else if (c == CHAR_PLUS) begin
                  ph = PH_DIGITS;
               end else if (is_digit) begin
                  take_digit(4'(c - CHAR_ZERO));
               end else begin
                  ph = PH_DONE;
               end
            end
            PH_DIGITS: begin
               if (is_digit) take_digit(4'(c - CHAR_ZERO));
               else ph = PH_DONE;
            end
            default: ;
         endcase
         if (last) begin
            if (ovf) r.value = neg ? NEG_MAG : POS_MAG;
            else if (neg) r.value = ~mag + 64'd1;
            else r.value = mag;
            r.overflowed = ovf;
            owed_q.push_back(r);
            clear_parse();
         end
      endfunction

      function void check_value(logic [63:0] v, logic o);
         parsed_type e;
         results_seen++;
         if (o) overflows_seen++;
         if (owed_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: value %0d overflowed %0b", $signed(v), o);
            return;
         end
         e = owed_q.pop_front();
         if (e.value !== v || e.overflowed !== o) begin
            failures++;
            if (failures <= 10)
               $display({"mismatch on result %0d: expected value %0d overflowed %0b,",
                         " got value %0d overflowed %0b"},
                        results_seen, $signed(e.value), e.overflowed, $signed(v), o);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [7:0] char_code
   logic        req_tlast  = 1'b0;   // end_of_string
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // [63:0] value (signed)
   logic [0:0]  rsp_tuser;           // [0] overflowed

   parsed_value_board_type sb;
   logic [7:0] text_q[$];
   int send_gap_pct = 15;
   int recv_gap_pct = 51;
   int chars_sent   = 0;
   int strings_sent = 0;
   int stall_cycles = 0;

   decimal_text_to_int64 uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver back-pressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_gap_pct);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_value(rsp_tdata, rsp_tuser[0]);
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("decimal_text_to_int64 test failed");
            $finish;
         end
      end
   end

   // one request; entered and left at a falling edge
   task automatic send_char(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_char(c, last);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
      text_q.delete();
      strings_sent++;
   endtask

   function automatic void add_str(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   function automatic void add_blanks(int n);
      for (int i = 0; i < n; i++)
         text_q.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB + 8'($urandom_range(4)));
   endfunction

   function automatic void add_digits(int n);
      for (int i = 0; i < n; i++) text_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
   endfunction

   function automatic void add_sign();
      case ($urandom_range(2))
         1: text_q.push_back(CHAR_PLUS);
         2: text_q.push_back(CHAR_MINUS);
         default: ;
      endcase
   endfunction

   function automatic void add_noise(int n);
      for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(255)));
   endfunction

   // one random string: mostly well-formed numbers, some near the 64-bit limit, some junk
   task automatic send_random_string();
      int kind;
      kind = $urandom_range(99);
      if (kind < 60) begin
         if ($urandom_range(1)) add_blanks($urandom_range(1, 3));
         add_sign();
         if ($urandom_range(4) == 0) add_digits($urandom_range(1, 20));
         else add_digits($urandom_range(1, 8));
         if ($urandom_range(9) < 3) add_noise($urandom_range(1, 2));
      end else if (kind < 80) begin
         // digits around the signed limit for either sign
         if ($urandom_range(1)) add_blanks($urandom_range(1, 2));
         add_sign();
         if ($urandom_range(4) == 0) add_str("00");
         if ($urandom_range(9) < 7) begin
            add_str("922337203685477580");
         end else begin
            add_str("9");
            add_digits(17);
         end
         add_digits($urandom_range(1, 2));
         if ($urandom_range(4) == 0) add_noise(1);
      end else if (kind < 92) begin
         add_noise($urandom_range(1, 6));
      end else begin
         // broken sequences: doubled sign or a sign after digits
         add_blanks($urandom_range(2));
         if ($urandom_range(1)) begin
            add_sign();
            text_q.push_back($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS);
            add_digits($urandom_range(1, 3));
         end else begin
            add_digits($urandom_range(1, 4));
            text_q.push_back($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS);
            add_digits($urandom_range(1, 3));
         end
      end
      send_text();
   endtask

   // hold the sender off until every owed value has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.owed_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: all white space kinds then a short number
      text_q.push_back(CHAR_SPACE);
      for (int c = CHAR_TAB; c <= CHAR_CR; c++) text_q.push_back(8'(c));
      add_str("42");
      send_text();
      // both extremes, and one past each
      add_str("-9223372036854775808");
      send_text();
      add_str("9223372036854775807");
      send_text();
      add_str("+9223372036854775808");
      send_text();
      add_str("-9223372036854775809");
      send_text();
      // bare signs, doubled sign, sign after digits
      add_str("-");
      send_text();
      add_str("+");
      send_text();
      add_str("+-5");
      send_text();
      add_str("12-3");
      send_text();
      // byte zero and high bytes as plain non-digits, then end on a digit
      text_q.push_back(8'h00);
      text_q.push_back(8'hFF);
      text_q.push_back(8'h80);
      add_str("7");
      send_text();
      // long run after overflow, leading zeros, characters after the number
      add_str("99999999999999999999999x1");
      send_text();
      add_str("007 5");
      send_text();
      drain_results();

      // random strings under three idle patterns
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin send_gap_pct = 15; recv_gap_pct = 51; end
            1: begin send_gap_pct = 51; recv_gap_pct = 15; end
            default: begin send_gap_pct = 0; recv_gap_pct = 0; end
         endcase
         while (chars_sent < (p + 1) * PHASE_CHARS) send_random_string();
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (sb.owed_q.size() != 0) begin
         $display("%0d expected values never arrived", sb.owed_q.size());
         sb.failures += sb.owed_q.size();
      end
      $display("sent %0d characters in %0d strings under three idle patterns",
               chars_sent, strings_sent);
      $display("checked %0d parsed values, %0d of them saturated, %0d failures",
               sb.results_seen, sb.overflows_seen, sb.failures);
      if (sb.failures == 0) begin
         $display("decimal_text_to_int64 test passed");
      end else begin
         $display("decimal_text_to_int64 test failed");
      end
      $finish;
   end

endmodule
